// ===== design/sbam_pkg.sv =====
package sbam_pkg;

  // Result status codes
  localparam logic [1:0] ST_MAPPED = 2'd0;
  localparam logic [1:0] ST_HOLE   = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;
  localparam logic [1:0] ST_LOADED = 2'd3;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_BAND_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_DISK_SIZE   = 2'd1;
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd2;

  // Field widths
  localparam int OFS_W   = 41;
  localparam int ENTRY_W = 32;
  localparam int BLK_W   = 6;
  localparam int FOFS_W  = 48;
  localparam int LEN_W   = 31;
  localparam int SHIFT_W = 5;
  localparam int ECNT_W  = 11;

  // Band geometry
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd30;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd20;
  localparam int WITHIN_W  = 30;  // offset inside the largest band
  localparam int BANDNO_W  = 32;  // band number at the smallest band
  localparam int IBLK_SHIFT = 12; // index blocks are 4096 bytes

  typedef logic [ENTRY_W+BLK_W-1:0] slot_word_t;

endpackage

// ===== design/sparse_band_address_map.sv =====
// Channel   | Ports                                           | Handshake
// ----------+-------------------------------------------------+---------------------------------
// input     | in_cmd in_slot in_band_entry in_index_block     | transfer when start & !busy
//           | in_disk_offset in_byte_count                    |
// result    | out_status out_file_offset out_chunk_length     | out_valid for one cycle, no stall
// config    | cfg_we cfg_index cfg_wdata                      | write when cfg_we, no wait
//
// A load or a rejected read gives its result in the cycle after the transfer; busy stays low.
// A read walks the slot table one slot per cycle through a single registered-read memory
// port and one compare unit, busy high meanwhile. A hit registers a mapped result; a miss over
// N = min(entry_count, TABLE_DEPTH) slots registers a hole once the last slot read has been
// compared, or with no slot reads when N is zero. The walk stops at the first hit.
// rst_n is synchronous and clears control state, not the slot table; the receiver cannot stall.
module sparse_band_address_map
  import sbam_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_cmd,
  input  logic [9:0]              in_slot,
  input  logic [ENTRY_W-1:0]      in_band_entry,
  input  logic [BLK_W-1:0]        in_index_block,
  input  logic [OFS_W-1:0]        in_disk_offset,
  input  logic signed [31:0]      in_byte_count,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [FOFS_W-1:0]       out_file_offset,
  output logic [LEN_W-1:0]        out_chunk_length,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [OFS_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  // Configuration registers
  logic [SHIFT_W-1:0] band_shift_r;
  logic [OFS_W-1:0]   disk_size_r;
  logic [ECNT_W-1:0]  entry_count_r;

  // Slot table
  slot_word_t mem [TABLE_DEPTH];
  slot_word_t rd_data_r;

  // Sequencer and request context
  logic              state_r, state_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic [CW-1:0]     limit_r, limit_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [BANDNO_W-1:0] band_no_r, band_no_nxt;
  logic [WITHIN_W-1:0] within_r, within_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [FOFS_W-1:0] out_fofs_r, out_fofs_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  // Request decode
  logic              accept;
  logic              load_we;
  logic [16:0]       slot_ext;
  logic [16:0]       ecnt_ext;
  logic [16:0]       lim_ext;
  logic [SHIFT_W-1:0] shift_c;
  logic [30:0]       band_bytes;
  logic [WITHIN_W-1:0] within_c;
  logic [OFS_W-1:0]  band_no_full;
  logic [30:0]       remaining;
  logic [LEN_W-1:0]  cnt_pos;
  logic [LEN_W-1:0]  count_c;
  logic              req_err;

  // Search datapath
  logic [ENTRY_W-1:0] rd_entry;
  logic [BLK_W-1:0]   rd_blk;
  logic               hit;
  logic [FOFS_W-1:0]  slot_base;
  logic [FOFS_W-1:0]  iblk_base;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign slot_ext = 17'(in_slot);
  assign load_we  = accept && (in_cmd == CMD_LOAD) && (slot_ext < DEPTH_W);

  always_comb begin
    shift_c = band_shift_r;
    if (band_shift_r < SHIFT_MIN) begin
      shift_c = SHIFT_MIN;
    end else if (band_shift_r > SHIFT_MAX) begin
      shift_c = SHIFT_MAX;
    end
  end

  // Band geometry: the band size is a power of two, so split by shift and mask
  assign band_bytes   = 31'd1 << shift_c;
  assign within_c     = WITHIN_W'(in_disk_offset & OFS_W'(band_bytes - 31'd1));
  assign band_no_full = in_disk_offset >> shift_c;
  assign remaining    = band_bytes - 31'(within_c);
  assign cnt_pos      = in_byte_count[LEN_W-1:0];
  assign count_c      = (cnt_pos > remaining) ? remaining : cnt_pos;
  assign req_err      = in_byte_count[31] || (in_disk_offset > disk_size_r);

  assign ecnt_ext = 17'(entry_count_r);
  assign lim_ext  = (ecnt_ext > DEPTH_W) ? DEPTH_W : ecnt_ext;

  // Compare the slot read last cycle; a zero entry marks an empty slot and never matches
  assign rd_entry = rd_data_r[ENTRY_W+BLK_W-1:BLK_W];
  assign rd_blk   = rd_data_r[BLK_W-1:0];
  assign hit      = rvalid_r && (rd_entry != '0) && ((rd_entry - 32'd1) == band_no_r);

  // Low bits of the slot base are zero below the band size: OR in the offset
  assign slot_base = (FOFS_W'(rd_idx_r) << shift_r) | FOFS_W'(within_r);
  assign iblk_base = FOFS_W'({1'b0, rd_blk} + 7'd1) << IBLK_SHIFT;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    limit_nxt      = limit_r;
    rvalid_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    band_no_nxt    = band_no_r;
    within_nxt     = within_r;
    shift_nxt      = shift_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_fofs_nxt   = out_fofs_r;
    out_len_nxt    = out_len_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOAD) begin
            // Table write happens in the memory block; acknowledge now
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_LOADED;
            out_fofs_nxt   = '0;
            out_len_nxt    = '0;
          end else if (req_err) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_ERROR;
            out_fofs_nxt   = '0;
            out_len_nxt    = '0;
          end else begin
            // Latch the request and start the slot walk at slot zero
            state_nxt   = S_SEARCH;
            addr_nxt    = '0;
            limit_nxt   = lim_ext[CW-1:0];
            band_no_nxt = band_no_full[BANDNO_W-1:0];
            within_nxt  = within_c;
            shift_nxt   = shift_c;
            count_nxt   = count_c;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MAPPED;
          out_fofs_nxt   = iblk_base + slot_base;
          out_len_nxt    = count_r;
        end else if (!rvalid_r && (addr_r >= limit_r)) begin
          // Nothing left in flight and no slot matched: a hole
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_HOLE;
          out_fofs_nxt   = '0;
          out_len_nxt    = count_r;
        end else if (addr_r < limit_r) begin
          // Issue the next slot read
          rvalid_nxt = 1'b1;
          rd_idx_nxt = addr_r[AW-1:0];
          addr_nxt   = addr_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Slot table: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[slot_ext[AW-1:0]] <= {in_band_entry, in_index_block};
    end
    rd_data_r <= mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_shift_r  <= SHIFT_RST;
      disk_size_r   <= '0;
      entry_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BAND_SHIFT:  band_shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_DISK_SIZE:   disk_size_r   <= cfg_wdata;
        CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[ECNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      limit_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
      addr_r      <= addr_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    band_no_r    <= band_no_nxt;
    within_r     <= within_nxt;
    shift_r      <= shift_nxt;
    count_r      <= count_nxt;
    out_status_r <= out_status_nxt;
    out_fofs_r   <= out_fofs_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_file_offset  = out_fofs_r;
  assign out_chunk_length = out_len_r;

`ifndef SYNTHESIS
  // A result leaves only as the sequencer returns to idle
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Every transfer either answers next cycle or starts a walk
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("transfer dropped");

  // The walk never reads past the latched slot limit
  a_addr_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (addr_r <= limit_r))
    else $error("slot walk past limit");
`endif

endmodule
